// ===== src/b64sc_pkg.sv =====
`timescale 1ns / 1ps

package b64sc_pkg;

  localparam int unsigned MaxResults = 4;

  localparam logic ModeEncode = 1'b0;
  localparam logic ModeDecode = 1'b1;

  // Register select is address bit 2: mode at 0x0, pad_char at 0x4.
  localparam logic RegMode = 1'b0;
  localparam logic RegPad  = 1'b1;

  localparam logic [7:0] PadReset = 8'd61;

  typedef struct packed {
    logic [17:0] held;
    logic [1:0]  cnt;
    logic        third_pad;
  } b64sc_state_t;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       err;
  } b64sc_res_t;

  typedef b64sc_res_t [MaxResults-1:0] b64sc_burst_t;

  function automatic logic [7:0] char_of(input logic [5:0] s);
    logic [7:0] c;
    if (s < 6'd26) begin
      c = 8'({2'b00, s}) + 8'd65;
    end else if (s < 6'd52) begin
      c = 8'({2'b00, s}) + 8'd71;
    end else if (s < 6'd62) begin
      c = 8'({2'b00, s}) - 8'd4;
    end else if (s == 6'd62) begin
      c = 8'd43;
    end else begin
      c = 8'd47;
    end
    return c;
  endfunction

  // Characters outside the alphabet decode as zero.
  function automatic logic [5:0] sextet_of(input logic [7:0] c);
    logic [5:0] s;
    if (c >= 8'd65 && c <= 8'd90) begin
      s = 6'(c - 8'd65);
    end else if (c >= 8'd97 && c <= 8'd122) begin
      s = 6'(c - 8'd71);
    end else if (c >= 8'd48 && c <= 8'd57) begin
      s = 6'(c + 8'd4);
    end else if (c == 8'd43) begin
      s = 6'd62;
    end else if (c == 8'd47) begin
      s = 6'd63;
    end else begin
      s = 6'd0;
    end
    return s;
  endfunction

endpackage

// ===== src/b64sc_unit.sv =====
`timescale 1ns / 1ps

module b64sc_unit (
  input  logic                    mode,
  input  logic [7:0]              pad_char,
  input  b64sc_pkg::b64sc_state_t st,
  input  logic [7:0]              data,
  input  logic                    last,
  output b64sc_pkg::b64sc_state_t st_nxt,
  output logic [2:0]              n_res,
  output b64sc_pkg::b64sc_burst_t res
);

  logic [5:0]  sx;
  logic        is_pad;
  logic [15:0] w_e16;
  logic [23:0] w_e24;
  logic [17:0] w_d18;
  logic [23:0] w_d24;

  always_comb begin
    sx     = b64sc_pkg::sextet_of(data);
    is_pad = (data == pad_char);
    w_e16  = {st.held[7:0], data};
    w_e24  = {st.held[15:0], data};
    w_d18  = {st.held[11:0], sx};
    w_d24  = {st.held, sx};

    st_nxt = st;
    n_res  = 3'd0;
    res    = '0;

    if (mode == b64sc_pkg::ModeEncode) begin
      case (st.cnt)
        2'd0: begin
          st_nxt.held = {10'd0, data};
          st_nxt.cnt  = 2'd1;
          if (last) begin
            n_res          = 3'd4;
            res[0].data    = b64sc_pkg::char_of(data[7:2]);
            res[1].data    = b64sc_pkg::char_of({data[1:0], 4'd0});
            res[2].data    = pad_char;
            res[3].data    = pad_char;
            res[3].last    = 1'b1;
            st_nxt.held    = '0;
            st_nxt.cnt     = 2'd0;
          end
        end
        2'd1: begin
          st_nxt.held = {2'd0, w_e16};
          st_nxt.cnt  = 2'd2;
          if (last) begin
            n_res          = 3'd4;
            res[0].data    = b64sc_pkg::char_of(w_e16[15:10]);
            res[1].data    = b64sc_pkg::char_of(w_e16[9:4]);
            res[2].data    = b64sc_pkg::char_of({w_e16[3:0], 2'd0});
            res[3].data    = pad_char;
            res[3].last    = 1'b1;
            st_nxt.held    = '0;
            st_nxt.cnt     = 2'd0;
          end
        end
        default: begin
          n_res       = 3'd4;
          res[0].data = b64sc_pkg::char_of(w_e24[23:18]);
          res[1].data = b64sc_pkg::char_of(w_e24[17:12]);
          res[2].data = b64sc_pkg::char_of(w_e24[11:6]);
          res[3].data = b64sc_pkg::char_of(w_e24[5:0]);
          res[3].last = last;
          st_nxt.held = '0;
          st_nxt.cnt  = 2'd0;
        end
      endcase
    end else begin
      case (st.cnt)
        2'd3: begin
          st_nxt.held      = '0;
          st_nxt.cnt       = 2'd0;
          st_nxt.third_pad = 1'b0;
          res[0].data      = w_d24[23:16];
          res[1].data      = w_d24[15:8];
          if (last && is_pad && st.third_pad) begin
            n_res       = 3'd1;
            res[0].last = 1'b1;
          end else if (last && is_pad) begin
            n_res       = 3'd2;
            res[1].last = 1'b1;
          end else begin
            n_res       = 3'd3;
            res[2].data = w_d24[7:0];
            res[2].last = last;
          end
        end
        default: begin
          if (st.cnt == 2'd2) begin
            st_nxt.third_pad = is_pad;
          end
          st_nxt.held = w_d18;
          st_nxt.cnt  = st.cnt + 2'd1;
          if (last) begin
            st_nxt.held      = '0;
            st_nxt.cnt       = 2'd0;
            st_nxt.third_pad = 1'b0;
            case (st.cnt)
              2'd0: begin
                n_res       = 3'd1;
                res[0].last = 1'b1;
                res[0].err  = 1'b1;
              end
              2'd1: begin
                n_res       = 3'd1;
                res[0].data = w_d18[11:4];
                res[0].last = 1'b1;
              end
              default: begin
                n_res       = 3'd2;
                res[0].data = w_d18[17:10];
                res[1].data = w_d18[9:2];
                res[1].last = 1'b1;
              end
            endcase
          end
        end
      endcase
    end
  end

endmodule

// ===== src/base64_stream_codec.sv =====
`timescale 1ns / 1ps

// The first result of an item passes through the input register, the burst buffer and the output register.
// While out_tready is high, one result per cycle leaves a four-entry burst buffer, decoding
// takes one character per cycle, and encoding is bounded by the four results of each group.
// Items that complete no group are taken every cycle.
// Reset (synchronous, active low) empties all stages, selects encode and sets pad_char to 61.
module base64_stream_codec (
  input  logic        clk,
  input  logic        rst_n,

  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,    // [7:0] in_byte
  input  logic        in_tlast,

  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,   // [7:0] out_byte
  output logic        out_tlast,
  output logic        out_tuser,   // [0] out_error

  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  logic                    mode_r;
  logic [7:0]              pad_r;
  b64sc_pkg::b64sc_state_t st_r;
  b64sc_pkg::b64sc_state_t st_nxt;

  logic                    in_v_r;
  logic [7:0]              in_data_r;
  logic                    in_last_r;

  b64sc_pkg::b64sc_burst_t burst_r;
  b64sc_pkg::b64sc_burst_t burst_new;
  logic [2:0]              burst_left_r;
  logic [2:0]              n_res;

  logic                    out_v_r;
  b64sc_pkg::b64sc_res_t   out_r;

  logic                    cfg_wr;
  logic                    mode_wr;
  logic                    move;
  logic                    burst_free;
  logic                    consume;

  b64sc_unit u_unit (
    .mode     (mode_r),
    .pad_char (pad_r),
    .st       (st_r),
    .data     (in_data_r),
    .last     (in_last_r),
    .st_nxt   (st_nxt),
    .n_res    (n_res),
    .res      (burst_new)
  );

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign mode_wr    = cfg_wr && (cfg_paddr[2] == b64sc_pkg::RegMode);

  always_comb begin
    cfg_prdata = '0;
    case (cfg_paddr[2])
      b64sc_pkg::RegMode: cfg_prdata = {31'd0, mode_r};
      b64sc_pkg::RegPad:  cfg_prdata = {24'd0, pad_r};
      default:            cfg_prdata = '0;
    endcase
  end

  assign move       = (burst_left_r != 3'd0) && (!out_v_r || out_tready);
  assign burst_free = (burst_left_r == 3'd0) || ((burst_left_r == 3'd1) && move);
  assign consume    = in_v_r && ((n_res == 3'd0) || burst_free);
  assign in_tready  = !in_v_r || consume;

  assign out_tvalid = out_v_r;
  assign out_tdata  = out_r.data;
  assign out_tlast  = out_r.last;
  assign out_tuser  = out_r.err;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r       <= b64sc_pkg::ModeEncode;
      pad_r        <= b64sc_pkg::PadReset;
      st_r         <= '0;
      in_v_r       <= 1'b0;
      burst_left_r <= 3'd0;
      out_v_r      <= 1'b0;
    end else begin
      if (cfg_wr) begin
        if (cfg_paddr[2] == b64sc_pkg::RegMode) begin
          mode_r <= cfg_pwdata[0];
        end else begin
          pad_r <= cfg_pwdata[7:0];
        end
      end

      if (mode_wr) begin
        st_r <= '0;
      end else if (consume) begin
        st_r <= st_nxt;
      end

      if (in_tvalid && in_tready) begin
        in_v_r <= 1'b1;
      end else if (consume) begin
        in_v_r <= 1'b0;
      end

      if (consume && (n_res != 3'd0)) begin
        burst_left_r <= n_res;
      end else if (move) begin
        burst_left_r <= burst_left_r - 3'd1;
      end

      if (move) begin
        out_v_r <= 1'b1;
      end else if (out_tready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_data_r <= in_tdata;
      in_last_r <= in_tlast;
    end
    if (consume && (n_res != 3'd0)) begin
      burst_r <= burst_new;
    end else if (move) begin
      burst_r <= {b64sc_pkg::b64sc_res_t'('0), burst_r[b64sc_pkg::MaxResults-1:1]};
    end
    if (move) begin
      out_r <= burst_r[0];
    end
  end

  a_burst_bound: assert property (@(posedge clk) disable iff (!rst_n)
    burst_left_r <= 3'(b64sc_pkg::MaxResults))
    else $error("Burst buffer count exceeds the group size.");

  a_mode_clear: assert property (@(posedge clk) disable iff (!rst_n)
    mode_wr |=> (st_r.cnt == 2'd0) && (st_r.held == 18'd0) && !st_r.third_pad)
    else $error("Open group survived a mode write.");

  a_encode_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    (mode_r == b64sc_pkg::ModeEncode) |-> (st_r.cnt != 2'd3))
    else $error("Encoder holds more than two bytes.");

  a_error_shape: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && out_r.err) |-> (out_r.last && (out_r.data == 8'd0)))
    else $error("Error transfer is not a final zero byte.");

endmodule

// ===== bench/base64_stream_codec_tb.sv =====
`timescale 1ns / 1ps

module base64_stream_codec_tb;

  localparam bit [511:0] B64_ALPHABET =
    "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";
  localparam logic [2:0] ADDR_MODE = {b64sc_pkg::RegMode, 2'b00};
  localparam logic [2:0] ADDR_PAD  = {b64sc_pkg::RegPad, 2'b00};
  localparam int CYCLE_LIMIT   = 400000;
  localparam int HOLD_CYCLES   = 400;
  localparam int SETTLE_CYCLES = 8;
  localparam int PHASE_ITEMS   = 27;
  localparam int NUM_PHASES    = 7;

  class b64_codec_tracker;
    logic                  mode;
    logic [7:0]            pad;
    logic [17:0]           held;
    logic [1:0]            cnt;
    logic                  third_pad;
    b64sc_pkg::b64sc_res_t expected_out[$];
    int                    errors;

    function new();
      mode = b64sc_pkg::ModeEncode;
      pad = b64sc_pkg::PadReset;
      errors = 0;
      clear();
    endfunction

    function void clear();
      held = '0;
      cnt = '0;
      third_pad = 1'b0;
    endfunction

    function void set_mode(logic m);
      mode = m;
      clear();
    endfunction

    function void set_pad(logic [7:0] p);
      pad = p;
    endfunction

    function int pending();
      return expected_out.size();
    endfunction

    function logic [7:0] to_char(logic [5:0] s);
      return B64_ALPHABET[8*(63-int'(s)) +: 8];
    endfunction

    function void push_result(logic [7:0] d, logic l, logic e);
      b64sc_pkg::b64sc_res_t r;
      r.data = d;
      r.last = l;
      r.err = e;
      expected_out.push_back(r);
    endfunction

    function void take_input(logic [7:0] b, logic l);
      logic [5:0]  s;
      logic [17:0] w18;
      logic [23:0] w24;
      logic        pad_hit;
      s = '0;
      for (int i = 0; i < 64; i++) begin
        if (B64_ALPHABET[8*(63-i) +: 8] == b) s = 6'(i);
      end
      pad_hit = (b == pad);
      if (mode == b64sc_pkg::ModeEncode) begin
        case (cnt)
          2'd0: begin
            held = {10'b0, b};
            cnt = 2'd1;
            if (l) begin
              push_result(to_char(b[7:2]), 1'b0, 1'b0);
              push_result(to_char({b[1:0], 4'b0}), 1'b0, 1'b0);
              push_result(pad, 1'b0, 1'b0);
              push_result(pad, 1'b1, 1'b0);
              clear();
            end
          end
          2'd1: begin
            held = {2'b0, held[7:0], b};
            cnt = 2'd2;
            if (l) begin
              push_result(to_char(held[15:10]), 1'b0, 1'b0);
              push_result(to_char(held[9:4]), 1'b0, 1'b0);
              push_result(to_char({held[3:0], 2'b0}), 1'b0, 1'b0);
              push_result(pad, 1'b1, 1'b0);
              clear();
            end
          end
          default: begin
            w24 = {held[15:0], b};
            push_result(to_char(w24[23:18]), 1'b0, 1'b0);
            push_result(to_char(w24[17:12]), 1'b0, 1'b0);
            push_result(to_char(w24[11:6]), 1'b0, 1'b0);
            push_result(to_char(w24[5:0]), l, 1'b0);
            clear();
          end
        endcase
      end else if (cnt != 2'd3) begin
        w18 = {held[11:0], s};
        if (cnt == 2'd2) third_pad = pad_hit;
        if (!l) begin
          held = w18;
          cnt = cnt + 2'd1;
        end else begin
          case (cnt)
            2'd0: push_result(8'd0, 1'b1, 1'b1);
            2'd1: push_result(w18[11:4], 1'b1, 1'b0);
            default: begin
              push_result(w18[17:10], 1'b0, 1'b0);
              push_result(w18[9:2], 1'b1, 1'b0);
            end
          endcase
          clear();
        end
      end else begin
        w24 = {held, s};
        if (l && pad_hit && third_pad) begin
          push_result(w24[23:16], 1'b1, 1'b0);
        end else if (l && pad_hit) begin
          push_result(w24[23:16], 1'b0, 1'b0);
          push_result(w24[15:8], 1'b1, 1'b0);
        end else begin
          push_result(w24[23:16], 1'b0, 1'b0);
          push_result(w24[15:8], 1'b0, 1'b0);
          push_result(w24[7:0], l, 1'b0);
        end
        clear();
      end
    endfunction

    function void check_output(logic [7:0] d, logic l, logic e);
      b64sc_pkg::b64sc_res_t want;
      if (expected_out.size() == 0) begin
        $error("unexpected result: out_byte=%02h out_last=%0b out_error=%0b", d, l, e);
        errors++;
        return;
      end
      want = expected_out.pop_front();
      if (want.data != d) begin
        $error("out_byte mismatch: expected %02h, actual %02h", want.data, d);
        errors++;
      end
      if (want.last != l) begin
        $error("out_last mismatch: expected %0b, actual %0b", want.last, l);
        errors++;
      end
      if (want.err != e) begin
        $error("out_error mismatch: expected %0b, actual %0b", want.err, e);
        errors++;
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = '0;
  logic        in_tlast = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [7:0]  out_tdata;
  logic        out_tlast;
  logic        out_tuser;
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [2:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  b64_codec_tracker codec = new();
  int tx_max_gap = 3;
  int rx_max_stall = 3;
  int rx_hold_req = 0;
  int items_sent = 0;
  int cycle_count = 0;

  logic       ph_mode [NUM_PHASES] = '{b64sc_pkg::ModeEncode, b64sc_pkg::ModeDecode,
                                       b64sc_pkg::ModeEncode, b64sc_pkg::ModeDecode,
                                       b64sc_pkg::ModeDecode, b64sc_pkg::ModeEncode,
                                       b64sc_pkg::ModeDecode};
  logic [7:0] ph_pad [NUM_PHASES] = '{8'd61, 8'd61, 8'd0, 8'd255, 8'd65, 8'd255, 8'd0};
  int         ph_tx [NUM_PHASES] = '{15, 0, 0, 15, 5, 15, 3};
  int         ph_rx [NUM_PHASES] = '{15, 0, 3, 15, 15, 0, 3};
  bit         ph_hold [NUM_PHASES] = '{0, 0, 1, 0, 0, 0, 0};
  bit         ph_pause [NUM_PHASES] = '{0, 0, 0, 1, 0, 1, 0};

  base64_stream_codec dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("base64_stream_codec regression: fail");
      $finish;
    end
  end

  initial begin : receiver
    int stall;
    forever begin
      stall = (rx_hold_req > 0) ? rx_hold_req : $urandom_range(0, rx_max_stall);
      rx_hold_req = 0;
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
      codec.check_output(out_tdata, out_tlast, out_tuser);
    end
  end

  task automatic set_register(input logic [2:0] addr, input logic [31:0] value);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= addr;
    cfg_pwdata <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    if (addr == ADDR_MODE) codec.set_mode(value[0]);
    else codec.set_pad(value[7:0]);
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    if (cfg_prdata != value) begin
      $error("cfg_prdata mismatch at %0h: expected %08h, actual %08h", addr, value, cfg_prdata);
      codec.errors++;
    end
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_item(input logic [7:0] b, input logic l);
    int gap;
    gap = $urandom_range(0, tx_max_gap);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= b;
    in_tlast <= l;
    do @(posedge clk); while (!in_tready);
    codec.take_input(b, l);
    items_sent++;
  endtask

  task automatic send_text(input string s, input logic end_last);
    for (int i = 0; i < s.len(); i++) begin
      send_item(s[i], end_last && (i == s.len() - 1));
    end
  endtask

  task automatic pause_for_results();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (codec.pending() != 0) @(posedge clk);
  endtask

  task automatic wait_idle();
    pause_for_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic [7:0] random_char();
    int r;
    int idx;
    r = $urandom_range(0, 15);
    idx = $urandom_range(0, 63);
    if (r == 0) return codec.pad;
    if (r <= 2) return 8'($urandom_range(0, 255));
    return B64_ALPHABET[8*(63-idx) +: 8];
  endfunction

  task automatic send_encode_msg();
    int len;
    len = $urandom_range(1, 7);
    for (int i = 0; i < len; i++) begin
      send_item(8'($urandom_range(0, 255)), i == len - 1);
    end
  endtask

  // Mostly well-formed text: whole groups, then a final group that may be padded,
  // short, a lone character, or carry a pad in the third place only.
  task automatic send_decode_msg();
    int         groups;
    int         kind;
    int         n;
    logic [7:0] fin [4];
    groups = $urandom_range(0, 2);
    kind = $urandom_range(0, 6);
    for (int g = 0; g < groups; g++) begin
      for (int i = 0; i < 4; i++) send_item(random_char(), 1'b0);
    end
    for (int i = 0; i < 4; i++) fin[i] = random_char();
    n = 4;
    case (kind)
      1: fin[3] = codec.pad;
      2: begin
        fin[2] = codec.pad;
        fin[3] = codec.pad;
      end
      3: n = 3;
      4: n = 2;
      5: n = 1;
      6: fin[2] = codec.pad;
      default: n = 4;
    endcase
    for (int i = 0; i < n; i++) send_item(fin[i], i == n - 1);
  endtask

  initial begin : stimulus
    int target;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    set_register(ADDR_MODE, 32'(b64sc_pkg::ModeEncode));
    set_register(ADDR_PAD, 32'(b64sc_pkg::PadReset));

    send_item(8'h00, 1'b1);
    send_item(8'hFF, 1'b0);
    send_item(8'h80, 1'b1);
    send_item(8'hFF, 1'b0);
    send_item(8'h00, 1'b0);
    send_item(8'hA5, 1'b1);
    send_item(8'h12, 1'b0);
    send_item(8'h34, 1'b0);
    wait_idle();
    set_register(ADDR_MODE, 32'(b64sc_pkg::ModeEncode));
    send_item(8'h4D, 1'b1);

    wait_idle();
    set_register(ADDR_MODE, 32'(b64sc_pkg::ModeDecode));
    send_text("=*/+9Q==", 1'b1);
    send_text("zA=", 1'b1);
    send_text("Q", 1'b1);
    send_text("ab", 1'b0);
    wait_idle();
    set_register(ADDR_PAD, 32'h2E);
    send_text("c.", 1'b1);

    for (int p = 0; p < NUM_PHASES; p++) begin
      wait_idle();
      set_register(ADDR_MODE, 32'(ph_mode[p]));
      set_register(ADDR_PAD, 32'(ph_pad[p]));
      tx_max_gap = ph_tx[p];
      rx_max_stall = ph_rx[p];
      if (ph_hold[p]) rx_hold_req = HOLD_CYCLES;
      target = items_sent + PHASE_ITEMS;
      while (items_sent < target) begin
        if (ph_pause[p] && $urandom_range(0, 3) == 0) pause_for_results();
        if (ph_mode[p] == b64sc_pkg::ModeEncode) send_encode_msg();
        else send_decode_msg();
      end
    end

    pause_for_results();
    repeat (20) @(posedge clk);
    if (codec.errors == 0 && codec.pending() == 0) begin
      $display("base64_stream_codec regression: pass");
    end else begin
      $display("base64_stream_codec regression: fail");
    end
    $finish;
  end

endmodule
